>>> sv/dhm_pkg.sv
// Shared constants, types and helpers for the modular exponentiation unit.
package dhm_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int COUNT_BITS   = $clog2(OPERAND_BITS);
   localparam int REQ_BITS     = ((4 * OPERAND_BITS + 7) / 8) * 8;
   localparam int RSP_FIELDS   = 3 * OPERAND_BITS;
   localparam int RSP_BITS     = ((RSP_FIELDS + 7) / 8) * 8;

   typedef logic [OPERAND_BITS-1:0] operand_type;

   // (x + y) mod m for x, y < m
   function automatic operand_type add_mod(operand_type x, operand_type y, operand_type m);
      logic [OPERAND_BITS:0] sum;
      logic [OPERAND_BITS:0] wrapped;
      begin
         sum     = {1'b0, x} + {1'b0, y};
         wrapped = sum - {1'b0, m};
         if (sum >= {1'b0, m}) begin
            add_mod = wrapped[OPERAND_BITS-1:0];
         end else begin
            add_mod = sum[OPERAND_BITS-1:0];
         end
      end
   endfunction

endpackage

>>> sv/diffie_hellman_modexp_unit.sv
// Diffie-Hellman public values and shared key by bit-serial modular exponentiation.
//
// req channel: one word carries base, modulus and both private exponents.
// rsp channel: one word carries public_a, public_b and shared_key; tuser
// flags a zero modulus, in which case the three values are zero.
// One word is worked on at a time; req_tready is high only while idle.
// The base is first reduced mod p by a restoring remainder, one bit per
// cycle. Then three exponentiations run, each scanning the exponent from
// the low bit up. Every modular product is a shift-and-add loop over the
// multiplier bits, one bit per cycle, and each exponent bit passes through
// a decision state, a squaring and, for a set bit, one extra product.
// A zero modulus goes straight to the output state.
// The finished word sits in an output register; the block then returns
// to idle and can take a new word while that word waits for rsp_tready.
// A later result waits in S_OUT until the output register is free.
// Reset (synchronous, active high) drops any word in progress and clears
// rsp_tvalid.
module diffie_hellman_modexp_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // base_value, modulus, secret_a, secret_b (lowest bits first)
   input  logic [dhm_pkg::REQ_BITS-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // public_a, public_b, shared_key (lowest bits first), zero padded
   output logic [dhm_pkg::RSP_BITS-1:0] rsp_tdata,
   // modulus_error
   output logic                        rsp_tuser
);
   import dhm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_POW_INIT,
      S_BIT,
      S_MUL,
      S_OUT
   } state_type;

   localparam logic [1:0] PHASE_A   = 2'd0;
   localparam logic [1:0] PHASE_B   = 2'd1;
   localparam logic [1:0] PHASE_KEY = 2'd2;

   localparam logic [COUNT_BITS-1:0] LAST_COUNT = COUNT_BITS'(OPERAND_BITS - 1);
   localparam operand_type ONE = operand_type'(1);

   state_type              state_ff;
   logic [1:0]             phase_ff;
   logic [COUNT_BITS-1:0]  bit_cnt_ff;
   logic [COUNT_BITS-1:0]  mul_cnt_ff;
   logic                   mul_res_ff;
   operand_type            mod_ff;
   operand_type            base_ff;
   operand_type            ea_ff;
   operand_type            eb_ff;
   operand_type            exp_ff;
   operand_type            res_ff;
   operand_type            sq_ff;
   operand_type            acc_ff;
   operand_type            run_ff;
   operand_type            mop_ff;
   operand_type            pa_ff;
   operand_type            pb_ff;
   operand_type            key_ff;
   logic                   err_ff;
   operand_type            rem_ff;
   logic                   rsp_valid_ff;
   logic [RSP_BITS-1:0]    rsp_data_ff;
   logic                   rsp_user_ff;

   operand_type            acc_in;
   operand_type            run_in;
   logic [OPERAND_BITS:0]  rem_shift;
   operand_type            rem_in;

   always_comb begin
      acc_in    = mop_ff[0] ? add_mod(acc_ff, run_ff, mod_ff) : acc_ff;
      run_in    = add_mod(run_ff, run_ff, mod_ff);
      rem_shift = {rem_ff, base_ff[OPERAND_BITS-1]};
      rem_in    = (rem_shift >= {1'b0, mod_ff})
                  ? operand_type'(rem_shift - {1'b0, mod_ff})
                  : rem_shift[OPERAND_BITS-1:0];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PHASE_A;
         bit_cnt_ff   <= '0;
         mul_cnt_ff   <= '0;
         mul_res_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  base_ff    <= req_tdata[OPERAND_BITS-1:0];
                  mod_ff     <= req_tdata[2*OPERAND_BITS-1:OPERAND_BITS];
                  ea_ff      <= req_tdata[3*OPERAND_BITS-1:2*OPERAND_BITS];
                  eb_ff      <= req_tdata[4*OPERAND_BITS-1:3*OPERAND_BITS];
                  rem_ff     <= '0;
                  bit_cnt_ff <= '0;
                  phase_ff   <= PHASE_A;
                  pa_ff      <= '0;
                  pb_ff      <= '0;
                  key_ff     <= '0;
                  if (req_tdata[2*OPERAND_BITS-1:OPERAND_BITS] == '0) begin
                     err_ff   <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     err_ff   <= 1'b0;
                     state_ff <= S_REDUCE;
                  end
               end
            end
            S_REDUCE: begin
               rem_ff     <= rem_in;
               base_ff    <= {base_ff[OPERAND_BITS-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == LAST_COUNT) begin
                  base_ff  <= rem_in;
                  state_ff <= S_POW_INIT;
               end
            end
            S_POW_INIT: begin
               res_ff     <= (mod_ff == ONE) ? '0 : ONE;
               sq_ff      <= (phase_ff == PHASE_KEY) ? pa_ff : base_ff;
               exp_ff     <= (phase_ff == PHASE_A) ? ea_ff : eb_ff;
               bit_cnt_ff <= '0;
               state_ff   <= S_BIT;
            end
            S_BIT: begin
               acc_ff     <= '0;
               mul_cnt_ff <= '0;
               mop_ff     <= sq_ff;
               mul_res_ff <= exp_ff[0];
               run_ff     <= exp_ff[0] ? res_ff : sq_ff;
               state_ff   <= S_MUL;
            end
            S_MUL: begin
               acc_ff     <= acc_in;
               run_ff     <= run_in;
               mop_ff     <= mop_ff >> 1;
               mul_cnt_ff <= mul_cnt_ff + 1'b1;
               if (mul_cnt_ff == LAST_COUNT) begin
                  mul_cnt_ff <= '0;
                  acc_ff     <= '0;
                  if (mul_res_ff) begin
                     // multiply done, now square
                     res_ff     <= acc_in;
                     mul_res_ff <= 1'b0;
                     run_ff     <= sq_ff;
                     mop_ff     <= sq_ff;
                  end else begin
                     sq_ff      <= acc_in;
                     exp_ff     <= exp_ff >> 1;
                     bit_cnt_ff <= bit_cnt_ff + 1'b1;
                     if (bit_cnt_ff == LAST_COUNT) begin
                        unique case (phase_ff)
                           PHASE_A: begin
                              pa_ff    <= res_ff;
                              phase_ff <= PHASE_B;
                              state_ff <= S_POW_INIT;
                           end
                           PHASE_B: begin
                              pb_ff    <= res_ff;
                              phase_ff <= PHASE_KEY;
                              state_ff <= S_POW_INIT;
                           end
                           default: begin
                              key_ff   <= res_ff;
                              state_ff <= S_OUT;
                           end
                        endcase
                     end else begin
                        state_ff <= S_BIT;
                     end
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RSP_BITS'({key_ff, pb_ff, pa_ff});
                  rsp_user_ff  <= err_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
